[design/bms_pkg.sv]
`timescale 1ns / 1ps

package bms_pkg;

    // Stack geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int LVL_W      = 4;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Command codes on the request channel
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_PEEK  = 2'd3;

    // Status codes on the response channel
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY_ERR = 2'd1;
    localparam logic [1:0] ST_FULL_ERR  = 2'd2;
    localparam logic [1:0] ST_PEEK_ERR  = 2'd3;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_CLEAR,
        OP_PEEK
    } op_kind_t;

    // One decoded command as it travels through the queue
    typedef struct packed {
        op_kind_t                      kind;
        logic signed [DATA_WIDTH-1:0]  value;
        logic [LVL_W-1:0]              level;
        logic [CNT_W-1:0]              cap;
    } op_t;

endpackage

[design/bms_if.sv]
`timescale 1ns / 1ps

interface bms_req_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              cmd;
    logic signed [bms_pkg::DATA_WIDTH-1:0]   push_value;
    logic [bms_pkg::LVL_W-1:0]               peek_depth;

    modport source (output valid, output cmd, output push_value, output peek_depth,
                    input ready);
    modport sink   (input valid, input cmd, input push_value, input peek_depth,
                    output ready);
endinterface

interface bms_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              status;
    logic signed [bms_pkg::DATA_WIDTH-1:0]   read_value;
    logic [bms_pkg::CNT_W-1:0]               count;
    logic signed [bms_pkg::DATA_WIDTH-1:0]   min_value;
    logic signed [bms_pkg::DATA_WIDTH-1:0]   max_value;
    logic                                    is_empty;
    logic                                    is_full;

    modport source (output valid, output status, output read_value, output count,
                    output min_value, output max_value, output is_empty, output is_full,
                    input ready);
    modport sink   (input valid, input status, input read_value, input count,
                    input min_value, input max_value, input is_empty, input is_full,
                    output ready);
endinterface

[design/bms_front.sv]
`timescale 1ns / 1ps

module bms_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    bms_req_if.sink                req,
    input  logic                   cfg_wr_en,
    input  logic [bms_pkg::CNT_W-1:0] cfg_wr_data,
    output logic                   q_valid,
    input  logic                   q_ready,
    output bms_pkg::op_t           q_op
);

    logic [bms_pkg::CNT_W-1:0] cap_reg;
    logic [bms_pkg::CNT_W-1:0] cap_eff;
    bms_pkg::op_kind_t         kind;

    // Hold the capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= bms_pkg::CNT_W'(bms_pkg::DEPTH);
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Clamp capacity into 1..DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = bms_pkg::CNT_W'(1);
        end
        else if (cap_reg > bms_pkg::CNT_W'(bms_pkg::DEPTH))
        begin
            cap_eff = bms_pkg::CNT_W'(bms_pkg::DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    // Decode the command
    always_comb
    begin
        case (req.cmd)
            bms_pkg::CMD_PUSH:  kind = bms_pkg::OP_PUSH;
            bms_pkg::CMD_POP:   kind = bms_pkg::OP_POP;
            bms_pkg::CMD_CLEAR: kind = bms_pkg::OP_CLEAR;
            bms_pkg::CMD_PEEK:  kind = bms_pkg::OP_PEEK;
            default:            kind = bms_pkg::OP_PEEK;
        endcase
    end

    // Forward the decoded command into the queue
    assign q_op.kind  = kind;
    assign q_op.value = req.push_value;
    assign q_op.level = req.peek_depth;
    assign q_op.cap   = cap_eff;
    assign q_valid    = req.valid;
    assign req.ready  = q_ready;

endmodule

[design/bms_queue.sv]
`timescale 1ns / 1ps

module bms_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  bms_pkg::op_t  wr_op,
    output logic          rd_valid,
    input  logic          rd_ready,
    output bms_pkg::op_t  rd_op
);

    bms_pkg::op_t               slot_reg [bms_pkg::QDEPTH];
    logic [bms_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [bms_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [bms_pkg::QCNT_W-1:0] cnt_reg;
    logic                       wr_fire;
    logic                       rd_fire;

    assign wr_ready = (cnt_reg != bms_pkg::QCNT_W'(bms_pkg::QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_op    = slot_reg[rd_ptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    // Store a transfer into the free slot
    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_fire && !rd_fire)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_fire && !wr_fire)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[design/bms_back.sv]
`timescale 1ns / 1ps

module bms_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  bms_pkg::op_t  q_op,
    bms_rsp_if.source     rsp
);

    localparam int DW = bms_pkg::DATA_WIDTH;
    localparam int CW = bms_pkg::CNT_W;
    localparam int PW = bms_pkg::PTR_W;

    // Stack storage, running minimum and maximum per level
    logic signed [DW-1:0] ent_mem_reg [bms_pkg::DEPTH];
    logic signed [DW-1:0] min_mem_reg [bms_pkg::DEPTH];
    logic signed [DW-1:0] max_mem_reg [bms_pkg::DEPTH];

    // Control state and cached top-of-stack extremes
    logic [CW-1:0]        fill_reg;
    logic [CW-1:0]        fill_next;
    logic signed [DW-1:0] cur_min_reg;
    logic signed [DW-1:0] cur_min_next;
    logic signed [DW-1:0] cur_max_reg;
    logic signed [DW-1:0] cur_max_next;

    // Result register
    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic signed [DW-1:0] rd_reg;
    logic signed [DW-1:0] rd_next;
    logic [CW-1:0]        count_reg;
    logic signed [DW-1:0] min_reg;
    logic signed [DW-1:0] max_reg;
    logic                 empty_reg;
    logic                 full_reg;

    logic                 fire;
    logic                 wr_en;
    logic signed [DW-1:0] push_min;
    logic signed [DW-1:0] push_max;
    logic [CW-1:0]        below_idx;
    logic [CW-1:0]        peek_idx;
    logic [CW-1:0]        level_ext;

    assign fire    = q_valid && (!out_valid_reg || rsp.ready);
    assign q_ready = !out_valid_reg || rsp.ready;

    assign level_ext = CW'(q_op.level);
    assign below_idx = fill_reg - CW'(2);
    assign peek_idx  = fill_reg - CW'(1) - level_ext;

    // Running extremes for a new top entry
    always_comb
    begin
        if (fill_reg == '0)
        begin
            push_min = q_op.value;
            push_max = q_op.value;
        end
        else
        begin
            push_min = (q_op.value < cur_min_reg) ? q_op.value : cur_min_reg;
            push_max = (cur_max_reg < q_op.value) ? q_op.value : cur_max_reg;
        end
    end

    // Execute the command at the head of the queue
    always_comb
    begin
        fill_next    = fill_reg;
        cur_min_next = cur_min_reg;
        cur_max_next = cur_max_reg;
        status_next  = bms_pkg::ST_OK;
        rd_next      = '0;
        wr_en        = 1'b0;
        case (q_op.kind)
            bms_pkg::OP_PUSH:
            begin
                if (fill_reg >= q_op.cap)
                begin
                    status_next = bms_pkg::ST_FULL_ERR;
                end
                else
                begin
                    wr_en        = 1'b1;
                    fill_next    = fill_reg + CW'(1);
                    cur_min_next = push_min;
                    cur_max_next = push_max;
                end
            end
            bms_pkg::OP_POP:
            begin
                if (fill_reg == '0)
                begin
                    status_next = bms_pkg::ST_EMPTY_ERR;
                end
                else
                begin
                    fill_next    = fill_reg - CW'(1);
                    cur_min_next = min_mem_reg[below_idx[PW-1:0]];
                    cur_max_next = max_mem_reg[below_idx[PW-1:0]];
                end
            end
            bms_pkg::OP_CLEAR:
            begin
                fill_next = '0;
            end
            bms_pkg::OP_PEEK:
            begin
                if (level_ext >= fill_reg)
                begin
                    status_next = bms_pkg::ST_PEEK_ERR;
                end
                else
                begin
                    rd_next = ent_mem_reg[peek_idx[PW-1:0]];
                end
            end
            default:
            begin
                status_next = bms_pkg::ST_OK;
            end
        endcase
    end

    // Write the new top entry
    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            ent_mem_reg[fill_reg[PW-1:0]] <= q_op.value;
            min_mem_reg[fill_reg[PW-1:0]] <= push_min;
            max_mem_reg[fill_reg[PW-1:0]] <= push_max;
        end
    end

    // Hold the top extremes and result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cur_min_reg <= cur_min_next;
            cur_max_reg <= cur_max_next;
            status_reg  <= status_next;
            rd_reg      <= rd_next;
            count_reg   <= fill_next;
            min_reg     <= (fill_next == '0) ? '0 : cur_min_next;
            max_reg     <= (fill_next == '0) ? '0 : cur_max_next;
            empty_reg   <= (fill_next == '0);
            full_reg    <= (fill_next >= q_op.cap);
        end
    end

    // Advance fill count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.read_value = rd_reg;
    assign rsp.count      = count_reg;
    assign rsp.min_value  = min_reg;
    assign rsp.max_value  = max_reg;
    assign rsp.is_empty   = empty_reg;
    assign rsp.is_full    = full_reg;

endmodule

[design/bounded_stack_with_min_max_top.sv]
// Bounded LIFO stack of signed 32-bit words with running minimum and maximum.
// Commands (push, pop, clear, peek at a depth below the top) arrive on the req
// channel and each produces exactly one response carrying status, peeked word,
// count, minimum, maximum and empty/full flags. The front decodes commands and
// attaches the clamped capacity (0 acts as 1, above 16 acts as 16); a two-entry
// queue decouples it from the back, which executes one command per cycle while
// the response register is free or being taken, against a 16-entry register
// file, and registers the response. Sustained rate is one command per clock
// when the response side does not stall; a request is stored in the queue, then
// executed, and its response is registered. Write capacity only while no
// commands are in flight.
`timescale 1ns / 1ps

module bounded_stack_with_min_max_top
(
    input  logic                      clk,
    input  logic                      rst_n,
    bms_req_if.sink                   req,
    bms_rsp_if.source                 rsp,
    input  logic                      cfg_wr_en,
    input  logic [bms_pkg::CNT_W-1:0] cfg_wr_data
);

    logic         fq_valid;
    logic         fq_ready;
    bms_pkg::op_t fq_op;
    logic         qb_valid;
    logic         qb_ready;
    bms_pkg::op_t qb_op;

    bms_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_op        (fq_op)
    );

    bms_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_op    (fq_op),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_op    (qb_op)
    );

    bms_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_op    (qb_op),
        .rsp     (rsp)
    );

    // An empty stack reports zero extremes
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.count == '0) |->
            rsp.is_empty && (rsp.min_value == '0) && (rsp.max_value == '0))
        else $error("empty stack reported nonzero extremes");

    // Running minimum never exceeds running maximum
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.min_value <= rsp.max_value))
        else $error("minimum above maximum");

    // Any failed command returns a zero read word
    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != bms_pkg::ST_OK) |-> (rsp.read_value == '0))
        else $error("read data on error status");

    // Count stays within the storage
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.count <= bms_pkg::CNT_W'(bms_pkg::DEPTH)))
        else $error("count beyond depth");

endmodule

[tb/bms_checker.sv]
`timescale 1ns / 1ps

module bms_checker
    import bms_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bms_req_if               req,
    bms_rsp_if               rsp,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic [1:0]                   status;
        logic signed [DATA_WIDTH-1:0] read_value;
        logic [CNT_W-1:0]             count;
        logic signed [DATA_WIDTH-1:0] min_value;
        logic signed [DATA_WIDTH-1:0] max_value;
        logic                         is_empty;
        logic                         is_full;
    } stack_result_t;

    // Shadow copy of the stack and its running extremes
    logic signed [DATA_WIDTH-1:0] shadow_word [DEPTH];
    logic signed [DATA_WIDTH-1:0] shadow_lo   [DEPTH];
    logic signed [DATA_WIDTH-1:0] shadow_hi   [DEPTH];
    int                           shadow_fill = 0;
    logic [CNT_W-1:0]             capacity_reg = CNT_W'(DEPTH);

    stack_result_t expected_results [$];
    int            fail_total = 0;

    // Clamp the capacity register: zero acts as one, anything above DEPTH as DEPTH
    function automatic int usable_capacity(input logic [CNT_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > DEPTH)
            return DEPTH;
        return int'(raw);
    endfunction

    // Execute one command on the shadow stack and build the response it produces
    function automatic stack_result_t run_stack_command(
        input logic [1:0]                   op,
        input logic signed [DATA_WIDTH-1:0] word,
        input logic [LVL_W-1:0]             lvl
    );
        stack_result_t res;
        int            limit;
        limit = usable_capacity(capacity_reg);
        res = '0;
        res.status = ST_OK;
        case (op)
            CMD_PUSH:
            begin
                if (shadow_fill >= limit)
                    res.status = ST_FULL_ERR;
                else
                begin
                    shadow_word[shadow_fill] = word;
                    if (shadow_fill == 0)
                    begin
                        shadow_lo[0] = word;
                        shadow_hi[0] = word;
                    end
                    else
                    begin
                        shadow_lo[shadow_fill] = (word < shadow_lo[shadow_fill-1]) ?
                                                 word : shadow_lo[shadow_fill-1];
                        shadow_hi[shadow_fill] = (word > shadow_hi[shadow_fill-1]) ?
                                                 word : shadow_hi[shadow_fill-1];
                    end
                    shadow_fill++;
                end
            end
            CMD_POP:
            begin
                if (shadow_fill == 0)
                    res.status = ST_EMPTY_ERR;
                else
                    shadow_fill--;
            end
            CMD_CLEAR:
            begin
                shadow_fill = 0;
            end
            CMD_PEEK:
            begin
                if (int'(lvl) >= shadow_fill)
                    res.status = ST_PEEK_ERR;
                else
                    res.read_value = shadow_word[shadow_fill - 1 - int'(lvl)];
            end
        endcase
        if (shadow_fill > 0)
        begin
            res.min_value = shadow_lo[shadow_fill-1];
            res.max_value = shadow_hi[shadow_fill-1];
        end
        res.count    = CNT_W'(shadow_fill);
        res.is_empty = (shadow_fill == 0);
        res.is_full  = (shadow_fill >= limit);
        return res;
    endfunction

    // Compare each response transfer against the oldest prediction, then predict new ones
    always @(posedge clk or negedge rst_n)
    begin : watch
        stack_result_t got;
        stack_result_t want;
        if (!rst_n)
        begin
            shadow_fill  = 0;
            capacity_reg = CNT_W'(DEPTH);
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status     = rsp.status;
                got.read_value = rsp.read_value;
                got.count      = rsp.count;
                got.min_value  = rsp.min_value;
                got.max_value  = rsp.max_value;
                got.is_empty   = rsp.is_empty;
                got.is_full    = rsp.is_full;
                if (expected_results.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("[%0t] unexpected response: st=%0d cnt=%0d", $realtime,
                                 got.status, got.count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.read_value !== want.read_value ||
                        got.count !== want.count || got.min_value !== want.min_value ||
                        got.max_value !== want.max_value || got.is_empty !== want.is_empty ||
                        got.is_full !== want.is_full)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                        begin
                            $display("[%0t] response mismatch", $realtime);
                            $display("  expected st=%0d rd=%0d cnt=%0d min=%0d max=%0d e=%0b f=%0b",
                                     want.status, want.read_value, want.count, want.min_value,
                                     want.max_value, want.is_empty, want.is_full);
                            $display("  actual   st=%0d rd=%0d cnt=%0d min=%0d max=%0d e=%0b f=%0b",
                                     got.status, got.read_value, got.count, got.min_value,
                                     got.max_value, got.is_empty, got.is_full);
                        end
                    end
                end
            end
            if (cfg_wr_en)
                capacity_reg = cfg_wr_data;
            if (req.valid && req.ready)
                expected_results.push_back(run_stack_command(req.cmd, req.push_value,
                                                             req.peek_depth));
            outstanding <= expected_results.size();
        end
        mismatches <= fail_total;
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import bms_pkg::*;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    int               mismatches;
    int               outstanding;
    int               burst_left = 0;
    rx_mode_t         rx_mode = RX_OPEN;
    int               rx_timer = 0;

    bms_req_if req_ch ();
    bms_rsp_if rsp_ch ();

    bounded_stack_with_min_max_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    bms_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Response side: switch at random between stall patterns
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rx_timer == 0)
            begin
                rx_mode  = rx_mode_t'($urandom_range(0, 3));
                rx_timer = $urandom_range(20, 80);
            end
            else
                rx_timer--;
            case (rx_mode)
                RX_OPEN:     rsp_ch.ready <= 1'b1;
                RX_MOSTLY:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: rsp_ch.ready <= (rx_timer % 5 != 0);
            endcase
        end
    end

    // Present one command and hold it until the transfer; open a new burst when due
    task automatic issue(input logic [1:0] op, input logic signed [DATA_WIDTH-1:0] word,
                         input logic [LVL_W-1:0] lvl);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && req_ch.valid)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= op;
        req_ch.push_value <= word;
        req_ch.peek_depth <= lvl;
        do
            @(posedge clk);
        while (!req_ch.ready);
        burst_left--;
    endtask

    // Drop valid and wait for every predicted response to come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CNT_W-1:0] cap);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] pick_word();
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return -32'sd1;
                    3:       return 32'sd1;
                    default: return 32'sd0;
                endcase
            end
            1:       return $signed(32'($urandom_range(0, 40))) - 32'sd20;
            default: return $signed($urandom());
        endcase
    endfunction

    // Random command mix; push share steers how full the stack runs
    task automatic random_phase(input int n, input int push_pct);
        int roll;
        int pop_pct;
        logic [LVL_W-1:0] lvl;
        pop_pct = $urandom_range(15, 30);
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            lvl  = ($urandom_range(0, 1) == 0) ? LVL_W'($urandom_range(0, 15)) :
                                                 LVL_W'($urandom_range(0, 4));
            if (roll < push_pct)
                issue(CMD_PUSH, pick_word(), lvl);
            else if (roll < push_pct + pop_pct)
                issue(CMD_POP, pick_word(), lvl);
            else if (roll < push_pct + pop_pct + 3)
                issue(CMD_CLEAR, pick_word(), lvl);
            else
                issue(CMD_PEEK, pick_word(), lvl);
        end
    endtask

    initial
    begin
        int cap_plan [10]  = '{16, 31, 2, 16, 1, 0, 12, 17, 3, 16};
        int push_plan [10] = '{45, 60, 40, 60, 35, 40, 60, 50, 40, 35};
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_PUSH;
        req_ch.push_value = '0;
        req_ch.peek_depth = '0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Errors on an empty stack, extreme words, peeks in and out of range
        set_capacity(CNT_W'(16));
        issue(CMD_POP,   32'sd0, 4'd0);
        issue(CMD_PEEK,  32'sd0, 4'd0);
        issue(CMD_PUSH,  32'sh7FFF_FFFF, 4'd0);
        issue(CMD_PUSH,  32'sh8000_0000, 4'd15);
        issue(CMD_PUSH,  -32'sd1, 4'd0);
        issue(CMD_PUSH,  32'sd0, 4'd0);
        issue(CMD_PEEK,  32'sd0, 4'd0);
        issue(CMD_PEEK,  32'sd0, 4'd3);
        issue(CMD_PEEK,  32'sd0, 4'd4);
        issue(CMD_PEEK,  -32'sd1, 4'd15);
        issue(CMD_POP,   32'sd0, 4'd0);
        issue(CMD_CLEAR, 32'sd0, 4'd0);
        issue(CMD_CLEAR, 32'sd0, 4'd0);

        // Single-entry capacity, then zero which acts as one
        set_capacity(CNT_W'(1));
        issue(CMD_PUSH, 32'sd5, 4'd0);
        issue(CMD_PUSH, 32'sd6, 4'd0);
        issue(CMD_PEEK, 32'sd0, 4'd0);
        set_capacity(CNT_W'(0));
        issue(CMD_PUSH, 32'sd7, 4'd0);
        issue(CMD_POP,  32'sd0, 4'd0);
        issue(CMD_POP,  32'sd0, 4'd0);

        // Random phases; capacity changes keep the stack contents, so lowering
        // it below the count after a push-heavy phase is exercised
        for (int p = 0; p < 10; p++)
        begin
            if (p == 9)
                set_capacity(CNT_W'($urandom_range(0, 31)));
            else
                set_capacity(CNT_W'(cap_plan[p]));
            random_phase(125, push_plan[p]);
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[bounded_stack_with_min_max_top.f]
design/bms_pkg.sv
design/bms_if.sv
design/bms_front.sv
design/bms_queue.sv
design/bms_back.sv
design/bounded_stack_with_min_max_top.sv
tb/bms_checker.sv
tb/tb_top.sv
